// File: sv/shs_pkg.sv
// Shared types, constants and SHA-256 functions for the stream hasher.
package shs_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BUF_WORDS   = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned BUF_AW      = 4;
    localparam int unsigned HASH_AW     = 3;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_ORD,
        S_OCAP,
        S_OSEND
    } t_state;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] r;
        case (t)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: sv/shs_if.sv
// Stream channel interfaces for the hasher input bytes and digest words.
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/shs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: byte intake, padding, compression and digest output.
//
//  channel  | dir | payload                                  | meaning
//  ---------+-----+------------------------------------------+------------------------------
//  i_in     | in  | data_byte, byte_present, end_of_message  | one message byte request
//  o_out    | out | digest_word, word_index, last_word       | one digest word request
//
// A byte request is taken while the unit is idle. The byte that completes a 64-byte block
// starts a compression: loading the schedule and working words from the block and hash
// memories, 64 rounds, then adding back into the hash memory. An end request pads at one
// byte per cycle, with one or two compressions, then emits eight words, each read, captured
// and offered in turn and held while the output stalls, then reloads the initial hash. After
// reset the same reload runs before the first request is taken. Input ready is low during all
// of this work; a stalled digest word simply waits.
module sha256_stream_hasher_unit
    import shs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    shs_in_if.sink   i_in,
    shs_out_if.source o_out
);

    t_state r_state, n_state;
    logic [6:0]  r_cnt;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [23:0] r_acc;
    logic        r_pad, r_first, r_spill, r_fin;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [2:0]  r_oi;
    logic [31:0] r_odata;
    logic        r_ovalid;

    // Block buffer memory: 16 big-endian words assembled from incoming bytes.
    logic               buf_we;
    logic [BUF_AW-1:0]  buf_waddr, buf_raddr;
    logic [WORD_W-1:0]  buf_wdata, buf_rdata;

    // Hash state memory: H0..H7.
    logic               hash_we;
    logic [HASH_AW-1:0] hash_waddr, hash_raddr;
    logic [WORD_W-1:0]  hash_wdata, hash_rdata;

    logic       in_acc;
    logic       byte_we;
    logic [7:0] byte_val;
    logic [7:0] pad_byte;
    logic [63:0] len_sh;
    logic [31:0] x1, x2, w_new;
    logic [2:0]  add_idx;

    shs_ram #(.WIDTH(WORD_W), .DEPTH(BUF_WORDS)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    shs_ram #(.WIDTH(WORD_W), .DEPTH(HASH_WORDS)) u_hash (
        .i_clk   (i_clk),
        .i_we    (hash_we),
        .i_waddr (hash_waddr),
        .i_wdata (hash_wdata),
        .i_raddr (hash_raddr),
        .o_rdata (hash_rdata)
    );

    assign in_acc = i_in.valid && i_in.ready;

    // Padding byte: the marker first, then zeros, then the length big-endian in the last
    // eight bytes of the final block.
    assign len_sh = r_bits >> {~r_fill[2:0], 3'b000};
    always_comb begin
        if (r_first) begin
            pad_byte = PAD_MARK;
        end else if ((r_fill[5:3] == 3'd7) && !r_spill) begin
            pad_byte = len_sh[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Round datapath and schedule expansion.
    assign x1 = r_v[7] + big1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + round_k(r_cnt[5:0]) + r_w[0];
    assign x2 = big0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = r_w[0] + sig0(r_w[1]) + r_w[9] + sig1(r_w[14]);
    assign add_idx = 3'(r_cnt - 7'd1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_cnt[2:0] == 3'd7) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present && r_fill == 6'd63) n_state = S_LOAD;
                    else if (i_in.end_of_message) n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (r_fill == 6'd63) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_cnt == 7'd16) n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_cnt == 7'd63) n_state = S_ADD;
            end
            S_ADD: begin
                if (r_cnt == 7'd8) begin
                    if (r_fin) n_state = S_ORD;
                    else if (r_pad) n_state = S_PAD;
                    else n_state = S_IDLE;
                end
            end
            S_ORD:  n_state = S_OCAP;
            S_OCAP: n_state = S_OSEND;
            S_OSEND: begin
                if (o_out.ready) n_state = (r_oi == 3'd7) ? S_INIT : S_ORD;
            end
            default: n_state = S_INIT;
        endcase
    end

    // Control outputs and memory ports.
    always_comb begin
        i_in.ready = 1'b0;
        byte_we    = 1'b0;
        byte_val   = i_in.data_byte;
        hash_we    = 1'b0;
        hash_waddr = r_cnt[2:0];
        hash_wdata = init_hash(r_cnt[2:0]);
        hash_raddr = r_cnt[2:0];
        buf_raddr  = r_cnt[3:0];
        case (r_state)
            S_INIT: begin
                hash_we = 1'b1;
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                byte_we    = in_acc && i_in.byte_present;
            end
            S_PAD: begin
                byte_we  = 1'b1;
                byte_val = pad_byte;
            end
            S_ADD: begin
                hash_we    = (r_cnt != 7'd0);
                hash_waddr = add_idx;
                hash_wdata = hash_rdata + r_v[add_idx];
            end
            S_ORD: begin
                hash_raddr = r_oi;
            end
            default: begin
            end
        endcase
    end

    assign buf_we    = byte_we && (r_fill[1:0] == 2'd3);
    assign buf_waddr = r_fill[5:2];
    assign buf_wdata = {r_acc, byte_val};

    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_odata;
    assign o_out.word_index  = r_oi;
    assign o_out.last_word   = (r_oi == 3'd7);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_bits   <= '0;
            r_pad    <= 1'b0;
            r_first  <= 1'b0;
            r_spill  <= 1'b0;
            r_fin    <= 1'b0;
            r_oi     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 7'd0 : r_cnt + 7'd1;

            if (r_state == S_INIT) begin
                r_fill  <= '0;
                r_bits  <= '0;
                r_pad   <= 1'b0;
                r_first <= 1'b0;
                r_spill <= 1'b0;
                r_fin   <= 1'b0;
                r_oi    <= '0;
            end

            if (in_acc) begin
                if (i_in.byte_present) r_bits <= r_bits + 64'd8;
                if (i_in.end_of_message) begin
                    r_pad   <= 1'b1;
                    r_first <= 1'b1;
                end
            end

            if (byte_we) r_fill <= r_fill + 6'd1;

            // The spill flag marks a padding block that is not the final one.
            if (r_state == S_PAD) begin
                r_first <= 1'b0;
                if (r_fill == 6'd63) begin
                    r_spill <= 1'b0;
                    if (!r_first && !r_spill) r_fin <= 1'b1;
                end else if (r_first) begin
                    r_spill <= (r_fill[5:3] == 3'd7);
                end
            end

            if (r_state == S_OCAP) r_ovalid <= 1'b1;
            if (r_state == S_OSEND && o_out.ready) begin
                r_ovalid <= 1'b0;
                r_oi     <= r_oi + 3'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (byte_we) r_acc <= {r_acc[15:0], byte_val};
        if (r_state == S_LOAD && r_cnt != 7'd0) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= buf_rdata;
            if (r_cnt <= 7'd8) r_v[add_idx] <= hash_rdata;
        end
        if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + x1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= x1 + x2;
        end
        if (r_state == S_OCAP) r_odata <= hash_rdata;
    end

    // The unit never takes a byte while a digest word is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while digest word pending");

    // The block buffer is never written while it is being read into the schedule.
    a_buf_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_ROUND) |-> !buf_we)
        else $error("block buffer written during compression");

    // Taking the last digest word restarts the hash state reload.
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> (r_state == S_INIT))
        else $error("no reload after last digest word");

endmodule
